// ===== src/cpet_pkg.sv =====
// Shared types and constants for the collision pair event tracker.
`timescale 1ns / 1ps

package cpet_pkg;

   // Field widths of one transfer
   localparam int unsigned ID_W    = 5;
   localparam int unsigned POS_W   = 24;
   localparam int unsigned SIZE_W  = 23;
   // Center difference and size sum carry one extra bit
   localparam int unsigned DIFF_W  = POS_W + 1;
   localparam int unsigned SUM_W   = SIZE_W + 1;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_ENTER = 2'd1,
      EV_STAY  = 2'd2,
      EV_EXIT  = 2'd3
   } cpet_event_type;

   typedef struct packed {
      logic        [ID_W-1:0]   left_id;
      logic        [ID_W-1:0]   right_id;
      logic signed [POS_W-1:0]  left_x;
      logic signed [POS_W-1:0]  left_y;
      logic signed [POS_W-1:0]  right_x;
      logic signed [POS_W-1:0]  right_y;
      logic        [SIZE_W-1:0] left_width;
      logic        [SIZE_W-1:0] left_height;
      logic        [SIZE_W-1:0] right_width;
      logic        [SIZE_W-1:0] right_height;
      logic                     left_dead;
      logic                     right_dead;
   } cpet_req_type;

   typedef struct packed {
      cpet_event_type event_res;
      logic           overlap;
   } cpet_rsp_type;

endpackage

// ===== src/cpet_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module cpet_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// ===== src/cpet_box_test.sv =====
// Axis-aligned box overlap test on registered center differences and size sums.
`timescale 1ns / 1ps

module cpet_box_test (
   input  logic signed [cpet_pkg::DIFF_W-1:0] dx,
   input  logic signed [cpet_pkg::DIFF_W-1:0] dy,
   input  logic        [cpet_pkg::SUM_W-1:0]  sum_w,
   input  logic        [cpet_pkg::SUM_W-1:0]  sum_h,
   output logic                               hit
);

   import cpet_pkg::*;

   logic [DIFF_W-1:0] mag_x;
   logic [DIFF_W-1:0] mag_y;
   logic              fit_x;
   logic              fit_y;

   // Magnitudes; the most negative difference cannot occur, so DIFF_W bits hold them
   assign mag_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
   assign mag_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

   // 2*|d| < sum on each axis
   assign fit_x = {mag_x, 1'b0} < {{(DIFF_W + 1 - SUM_W){1'b0}}, sum_w};
   assign fit_y = {mag_y, 1'b0} < {{(DIFF_W + 1 - SUM_W){1'b0}}, sum_h};

   assign hit = fit_x && fit_y;

endmodule

// ===== src/collision_pair_event_tracker_core.sv =====
// Top level of the collision pair event tracker: pair-state memory, event decision, output register.
`timescale 1ns / 1ps

// Takes one ordered collider pair per transfer and returns one result per pair:
// the box overlap flag and a none/enter/stay/exit event from the pair's active
// bit. Sustained rate is one pair per clock while the output side is not
// stalled. A result passes through the decision stage and the output register.
// The rate is set by the read-modify-write of the single-bit pair-state memory
// (one read and one write port), where the last write is forwarded to the next
// read of the same pair. After reset a clearing pass writes all 2^(2*ID_BITS)
// entries, one per cycle, with req_stall held high. Ids are reduced to their low
// ID_BITS bits for indexing and for the equal-id check; an equal-id pair reports
// none and leaves the state alone.

module collision_pair_event_tracker_core #(
   parameter int unsigned ID_BITS = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cpet_pkg::cpet_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cpet_pkg::cpet_rsp_type rsp_data
);

   import cpet_pkg::*;

   localparam int unsigned ADDR_W = 2 * ID_BITS;
   localparam int unsigned DEPTH  = 1 << ADDR_W;

   // Clearing pass
   logic                     clear_ff,     clear_in;
   logic [ADDR_W-1:0]        clear_cnt_ff, clear_cnt_in;

   // Decision stage
   logic                     s1_valid_ff,  s1_valid_in;
   logic [ADDR_W-1:0]        s1_addr_ff;
   logic                     s1_same_ff;
   logic                     s1_dead_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff;
   logic signed [DIFF_W-1:0] s1_dy_ff;
   logic [SUM_W-1:0]         s1_sw_ff;
   logic [SUM_W-1:0]         s1_sh_ff;

   // Last pair-state write
   logic                     fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]        fwd_addr_ff,  fwd_addr_in;
   logic                     fwd_data_ff,  fwd_data_in;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   cpet_rsp_type             rsp_data_ff,  rsp_data_in;

   logic                     req_accept;
   logic                     s1_go;
   logic [ID_BITS-1:0]       req_lid;
   logic [ID_BITS-1:0]       req_rid;
   logic [ADDR_W-1:0]        req_addr;
   logic [ADDR_W-1:0]        rd_addr;
   logic [0:0]               rd_data;
   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [0:0]               ram_wr_data;
   logic                     hit;
   logic                     active;
   logic                     item_wr;
   logic                     item_wr_data;
   cpet_event_type           ev;

   // Handshake
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clear_ff || (s1_valid_ff && !s1_go);
   assign req_accept = req_valid && !req_stall;

   // Pair index from the low id bits
   assign req_lid  = ID_BITS'(req_data.left_id);
   assign req_rid  = ID_BITS'(req_data.right_id);
   assign req_addr = {req_lid, req_rid};

   // Read the new pair on a transfer, otherwise keep re-reading the held one
   assign rd_addr = req_accept ? req_addr : s1_addr_ff;

   cpet_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_pair_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   cpet_box_test u_box_test (
      .dx    (s1_dx_ff),
      .dy    (s1_dy_ff),
      .sum_w (s1_sw_ff),
      .sum_h (s1_sh_ff),
      .hit   (hit)
   );

   // Active bit, with the last write forwarded over the read-first memory
   assign active = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data[0];

   // Event decision
   always_comb begin
      ev           = EV_NONE;
      item_wr      = 1'b0;
      item_wr_data = 1'b0;
      if (!s1_same_ff) begin
         if (hit) begin
            if (!active) begin
               ev           = EV_ENTER;
               item_wr      = 1'b1;
               item_wr_data = 1'b1;
            end else if (s1_dead_ff) begin
               ev           = EV_EXIT;
               item_wr      = 1'b1;
            end else begin
               ev           = EV_STAY;
            end
         end else if (active) begin
            ev           = EV_EXIT;
            item_wr      = 1'b1;
         end
      end
   end

   // Memory write: clearing pass or a state change that leaves the stage
   assign ram_wr_en   = clear_ff || (s1_go && item_wr);
   assign ram_wr_addr = clear_ff ? clear_cnt_ff : s1_addr_ff;
   assign ram_wr_data = clear_ff ? 1'b0 : item_wr_data;

   // Next-state logic
   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == {ADDR_W{1'b1}}) begin
            clear_in = 1'b0;
         end
      end

      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      if (clear_ff) begin
         fwd_valid_in = 1'b0;
      end else if (s1_go && item_wr) begin
         fwd_valid_in = 1'b1;
         fwd_addr_in  = s1_addr_ff;
         fwd_data_in  = item_wr_data;
      end

      rsp_data_in = rsp_data_ff;
      if (s1_go) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.event_res = ev;
         rsp_data_in.overlap   = hit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         s1_addr_ff <= req_addr;
         s1_same_ff <= (req_lid == req_rid);
         s1_dead_ff <= req_data.left_dead || req_data.right_dead;
         s1_dx_ff   <= {req_data.right_x[POS_W-1], req_data.right_x}
                     - {req_data.left_x[POS_W-1], req_data.left_x};
         s1_dy_ff   <= {req_data.right_y[POS_W-1], req_data.right_y}
                     - {req_data.left_y[POS_W-1], req_data.left_y};
         s1_sw_ff   <= {1'b0, req_data.left_width} + {1'b0, req_data.right_width};
         s1_sh_ff   <= {1'b0, req_data.left_height} + {1'b0, req_data.right_height};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/cpet_checker.sv =====
// Port-level checks for the collision pair event tracker, bound to the top level.
`timescale 1ns / 1ps

module cpet_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input cpet_pkg::cpet_rsp_type rsp_data
);

   import cpet_pkg::*;

   // Clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request side open right after reset");

   // No result straight out of reset
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Enter and stay only come with an overlap
   a_touch_needs_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == EV_ENTER || rsp_data.event_res == EV_STAY)
      |-> rsp_data.overlap)
      else $error("enter or stay without overlap");

   // A stalled result stays valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

endmodule

bind collision_pair_event_tracker_core cpet_checker u_cpet_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== bench/collision_pair_event_tracker_core_tb.sv =====
// Testbench for the collision pair event tracker core: directed and random pairs.
`timescale 1ns / 1ps

module collision_pair_event_tracker_core_tb;
   import cpet_pkg::*;

   localparam int unsigned PAIR_SLOTS   = 1 << (2 * ID_W);
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned RANDOM_PAIRS = 720;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_LIMIT  = 20000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   cpet_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   cpet_rsp_type rsp_data;

   // Predictor state: one touching bit per ordered pair
   bit           touching [PAIR_SLOTS];
   cpet_rsp_type pending_results [$];

   int unsigned  mismatches    = 0;
   int unsigned  event_tally [4];
   int unsigned  input_stalls  = 0;
   int unsigned  pairs_sent    = 0;
   int unsigned  burst_left    = 0;

   // Receiver stall control
   bit           hold_start    = 1'b0;
   int unsigned  hold_left     = 0;
   int unsigned  stall_mode    = 0;
   int unsigned  mode_left     = 0;

   collision_pair_event_tracker_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Overlap test and enter/stay/exit decision; updates the touching bits
   function automatic cpet_rsp_type predict_pair_event(input cpet_req_type r);
      longint       dx;
      longint       dy;
      longint       sum_w;
      longint       sum_h;
      logic         hit;
      logic         was_touching;
      logic [9:0]   slot;
      cpet_rsp_type res;
      dx = longint'($signed(r.right_x)) - longint'($signed(r.left_x));
      dy = longint'($signed(r.right_y)) - longint'($signed(r.left_y));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sum_w = longint'(r.left_width) + longint'(r.right_width);
      sum_h = longint'(r.left_height) + longint'(r.right_height);
      hit = (2 * dx < sum_w) && (2 * dy < sum_h);
      res.overlap   = hit;
      res.event_res = EV_NONE;
      // Equal ids never touch the state
      if (r.left_id != r.right_id) begin
         slot = {r.left_id, r.right_id};
         was_touching = touching[slot];
         if (hit && !was_touching) begin
            res.event_res = EV_ENTER;
            touching[slot] = 1'b1;
         end else if (hit && !(r.left_dead || r.right_dead)) begin
            res.event_res = EV_STAY;
         end else if (was_touching) begin
            res.event_res = EV_EXIT;
            touching[slot] = 1'b0;
         end
      end
      return res;
   endfunction

   function automatic cpet_req_type box_pair(input int lid, input int rid,
                                             input int lx, input int ly,
                                             input int rx, input int ry,
                                             input int lw, input int lh,
                                             input int rw, input int rh,
                                             input bit ld, input bit rd);
      cpet_req_type r;
      r.left_id      = ID_W'(lid);
      r.right_id     = ID_W'(rid);
      r.left_x       = POS_W'(lx);
      r.left_y       = POS_W'(ly);
      r.right_x      = POS_W'(rx);
      r.right_y      = POS_W'(ry);
      r.left_width   = SIZE_W'(lw);
      r.left_height  = SIZE_W'(lh);
      r.right_width  = SIZE_W'(rw);
      r.right_height = SIZE_W'(rh);
      r.left_dead    = ld;
      r.right_dead   = rd;
      return r;
   endfunction

   // Every field fully random, so every bit toggles
   function automatic cpet_req_type noise_pair();
      return box_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom_range(0, 1), $urandom_range(0, 1));
   endfunction

   // Boxes placed near each other; want_hit aims at touching or picks just apart
   function automatic cpet_req_type near_pair(input int lid, input int rid, input bit want_hit);
      int lw, lh, rw, rh, cx, cy, ox, oy;
      bit miss_x;
      lw = $urandom_range(0, 4096);
      rw = $urandom_range(0, 4096);
      lh = $urandom_range(0, 4096);
      rh = $urandom_range(0, 4096);
      cx = int'($urandom_range(0, 2000000)) - 1000000;
      cy = int'($urandom_range(0, 2000000)) - 1000000;
      ox = $urandom_range(0, (lw + rw) / 2);
      oy = $urandom_range(0, (lh + rh) / 2);
      if (!want_hit) begin
         miss_x = $urandom_range(0, 1);
         if (miss_x) ox = $urandom_range((lw + rw + 1) / 2, lw + rw + 1000);
         else oy = $urandom_range((lh + rh + 1) / 2, lh + rh + 1000);
      end
      if ($urandom_range(0, 1)) ox = -ox;
      if ($urandom_range(0, 1)) oy = -oy;
      return box_pair(lid, rid, cx, cy, cx + ox, cy + oy, lw, lh, rw, rh,
                      $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
   endfunction

   // Offer one pair in bursts with random gaps; returns once the transfer is taken
   task automatic send_pair(input cpet_req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      pairs_sent++;
   endtask

   task automatic test_enter_stay_exit();
      send_pair(box_pair(1, 2, 0, 0, 10, 0, 40, 40, 40, 40, 0, 0));
      send_pair(box_pair(1, 2, 0, 0, 20, 5, 40, 40, 40, 40, 0, 0));
      send_pair(box_pair(1, 2, 0, 0, -30, -5, 40, 40, 40, 40, 0, 0));
      send_pair(box_pair(1, 2, 0, 0, 1000, 0, 40, 40, 40, 40, 0, 0));
      send_pair(box_pair(1, 2, 0, 0, 1000, 0, 40, 40, 40, 40, 0, 0));
   endtask

   // Dead flags only matter once the pair is already touching
   task automatic test_dead_objects();
      send_pair(box_pair(5, 6, 0, 0, 10, 10, 40, 40, 40, 40, 1, 0));
      send_pair(box_pair(5, 6, 0, 0, 10, 10, 40, 40, 40, 40, 1, 0));
      send_pair(box_pair(5, 6, 0, 0, 10, 10, 40, 40, 40, 40, 0, 0));
      send_pair(box_pair(5, 6, 0, 0, 10, 10, 40, 40, 40, 40, 0, 1));
      send_pair(box_pair(5, 6, 0, 0, 900, 10, 40, 40, 40, 40, 1, 1));
   endtask

   task automatic test_equal_ids();
      send_pair(box_pair(7, 7, 0, 0, 1, 1, 40, 40, 40, 40, 0, 0));
      send_pair(box_pair(7, 7, 0, 0, 500, 1, 40, 40, 40, 40, 0, 0));
   endtask

   // (a,b) and (b,a) are separate entries
   task automatic test_ordered_pairs();
      send_pair(box_pair(3, 4, 0, 0, 5, 5, 40, 40, 40, 40, 0, 0));
      send_pair(box_pair(4, 3, 0, 0, 5, 5, 40, 40, 40, 40, 0, 0));
      send_pair(box_pair(3, 4, 0, 0, 5, 5, 40, 40, 40, 40, 0, 0));
   endtask

   // Coordinate and size extremes, zero sizes, and the exact edge of the test
   task automatic test_extremes();
      send_pair(box_pair(0, 31, -8388608, -8388608, 8388607, 8388607,
                         8388607, 8388607, 8388607, 8388607, 0, 0));
      send_pair(box_pair(0, 31, -8388608, 8388607, -8388608, 8388607,
                         8388607, 8388607, 8388607, 8388607, 0, 0));
      send_pair(box_pair(0, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(box_pair(31, 0, 0, 0, 100, 0, 100, 5000, 100, 5000, 0, 0));
      send_pair(box_pair(31, 0, 0, 0, 99, 0, 100, 5000, 100, 5000, 0, 0));
      send_pair(box_pair(31, 0, 0, 0, 0, -100, 5000, 100, 5000, 100, 0, 0));
   endtask

   // Pairs from a small id pool run through enter/stay/exit; some pure noise mixed in
   task automatic test_random_pairs();
      int unsigned start;
      int unsigned run_len;
      int          lid;
      int          rid;
      start = pairs_sent;
      while (pairs_sent - start < RANDOM_PAIRS) begin
         if ($urandom_range(0, 9) < 2) begin
            send_pair(noise_pair());
         end else begin
            lid = $urandom_range(0, 7);
            rid = $urandom_range(0, 7);
            run_len = $urandom_range(1, 6);
            repeat (run_len) send_pair(near_pair(lid, rid, 1'b1));
            if ($urandom_range(0, 9) < 7) send_pair(near_pair(lid, rid, 1'b0));
         end
      end
   endtask

   // Receiver holds off for a long stretch while pairs keep coming
   task automatic test_output_backpressure();
      hold_start = 1'b1;
      repeat (60) send_pair(near_pair($urandom_range(8, 11), $urandom_range(8, 11),
                                      $urandom_range(0, 3) != 0));
   endtask

   // Receiver stall pattern: modes change every so often, plus the long hold
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left  = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(32, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ~rsp_stall;
            end
         endcase
      end
   end

   // Predict on each input transfer, check each result transfer
   always @(posedge clock) begin
      cpet_rsp_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_stalls++;
         if (req_valid && !req_stall) begin
            want = predict_pair_event(req_data);
            pending_results.push_back(want);
            event_tally[want.event_res]++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: event %0d overlap %0d",
                           rsp_data.event_res, rsp_data.overlap);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.event_res !== want.event_res ||
                   rsp_data.overlap !== want.overlap) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result mismatch: event exp %0d got %0d, overlap exp %0d got %0d",
                              want.event_res, rsp_data.event_res,
                              want.overlap, rsp_data.overlap);
               end
            end
         end
      end
   end

   initial begin
      int unsigned drain;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_enter_stay_exit();
      test_dead_objects();
      test_equal_ids();
      test_ordered_pairs();
      test_extremes();
      test_output_backpressure();
      test_random_pairs();
      req_valid <= 1'b0;
      drain = 0;
      while (pending_results.size() > 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      $display("Covered %0d pairs: %0d none, %0d enter, %0d stay, %0d exit",
               pairs_sent, event_tally[EV_NONE], event_tally[EV_ENTER],
               event_tally[EV_STAY], event_tally[EV_EXIT]);
      $display("Input held off for %0d cycles, %0d mismatches", input_stalls, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
src/cpet_pkg.sv
src/cpet_ram.sv
src/cpet_box_test.sv
src/collision_pair_event_tracker_core.sv
src/cpet_checker.sv
bench/collision_pair_event_tracker_core_tb.sv
